[sv/lpm_pkg.sv]
// shared types and codes for the longest prefix match table
package lpm_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PORT_W = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_HIT      = 2'd2,
        STAT_MISS     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS,
        ST_LKP,
        ST_RESULT
    } t_state;

    // one stored route, dest in the low bits
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] gateway;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] dest;
    } t_route;

    localparam int unsigned ROUTE_W = $bits(t_route);

endpackage

[sv/longest_prefix_match_table.sv]
// longest prefix match forwarding table, sorted route memory walked one entry a cycle
//
//  channel  dir  tdata                                          tuser
//  s_axis   in   dest, mask, gateway, port, packet_addr (144b)   op (1b)
//  m_axis   out  hit_gateway, hit_port (48b)                    status (2b)
//
// a lookup or an insert walks the route memory, one read per cycle;
// a refused insert on a full table skips the walk.
// reset empties the table at once; entries are only read below the route count.
// a result waiting on m_axis holds only the final step; the next beat is taken meanwhile.
module longest_prefix_match_table
    import lpm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,  // route_dest, route_mask, route_gateway, route_port,
                                        // packet_addr
    input  logic [0:0]   s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,  // hit_gateway, hit_port
    output logic [1:0]   m_axis_tuser   // status
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_rd_left, n_rd_left;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic [AW-1:0]     r_vidx, n_vidx;
    logic              r_vld, n_vld;
    t_op               r_op, n_op;
    t_route            r_new, n_new;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_status           r_res_status, n_res_status;
    logic [ADDR_W-1:0] r_res_gw, n_res_gw;
    logic [PORT_W-1:0] r_res_port, n_res_port;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [ADDR_W-1:0] r_out_gw, n_out_gw;
    logic [PORT_W-1:0] r_out_port, n_out_port;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_route            ram_wdata;
    t_route            ram_rdata;
    logic              cmp_hit;
    logic [ADDR_W-1:0] cmp_key;
    logic              issue;
    logic              s_accept;

    lpm_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    assign cmp_key = (r_op == OP_INSERT) ? r_new.mask : r_addr;

    lpm_cmp u_cmp (
        .i_op    (r_op),
        .i_entry (ram_rdata),
        .i_key   (cmp_key),
        .o_hit   (cmp_hit)
    );

    assign s_axis_tready = i_rst_n && (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign issue         = (r_rd_left != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_left   <= '0;
            r_vld       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_left   <= n_rd_left;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr    <= n_rd_addr;
        r_vidx       <= n_vidx;
        r_op         <= n_op;
        r_new        <= n_new;
        r_addr       <= n_addr;
        r_res_status <= n_res_status;
        r_res_gw     <= n_res_gw;
        r_res_port   <= n_res_port;
        r_out_status <= n_out_status;
        r_out_gw     <= n_out_gw;
        r_out_port   <= n_out_port;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_left    = r_rd_left;
        n_rd_addr    = r_rd_addr;
        n_vidx       = r_vidx;
        n_vld        = r_vld;
        n_op         = r_op;
        n_new        = r_new;
        n_addr       = r_addr;
        n_res_status = r_res_status;
        n_res_gw     = r_res_gw;
        n_res_port   = r_res_port;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_gw     = r_out_gw;
        n_out_port   = r_out_port;
        ram_we       = 1'b0;
        ram_waddr    = r_vidx + AW'(1);
        ram_wdata    = ram_rdata;

        case (r_state)
            ST_IDLE: begin
                n_vld = 1'b0;
                if (s_accept) begin
                    n_op          = t_op'(s_axis_tuser[0]);
                    n_new.dest    = s_axis_tdata[31:0];
                    n_new.mask    = s_axis_tdata[63:32];
                    n_new.gateway = s_axis_tdata[95:64];
                    n_new.port    = s_axis_tdata[111:96];
                    n_addr        = s_axis_tdata[143:112];
                    n_rd_left     = r_count;
                    n_res_gw      = '0;
                    n_res_port    = '0;
                    if (t_op'(s_axis_tuser[0]) == OP_LOOKUP) begin
                        n_rd_addr = '0;
                        n_state   = ST_LKP;
                    end else if (r_count == CW'(TABLE_DEPTH)) begin
                        n_rd_left    = '0;
                        n_res_status = STAT_FULL;
                        n_state      = ST_RESULT;
                    end else begin
                        // walk from the last route down, shifting each one up
                        n_rd_addr = AW'(r_count - CW'(1));
                        n_state   = ST_INS;
                    end
                end
            end
            ST_INS: begin
                n_vld  = issue;
                n_vidx = r_rd_addr;
                if (issue) begin
                    n_rd_left = r_rd_left - CW'(1);
                    n_rd_addr = r_rd_addr - AW'(1);
                end
                if (r_vld) begin
                    ram_we = 1'b1;
                    if (!cmp_hit) begin
                        // stored mask is longer: new route lands just behind it
                        ram_wdata    = r_new;
                        n_vld        = 1'b0;
                        n_rd_left    = '0;
                        n_count      = r_count + CW'(1);
                        n_res_status = STAT_INSERTED;
                        n_state      = ST_RESULT;
                    end
                end else if (!issue) begin
                    // every route moved up, new one goes to the head
                    ram_we       = 1'b1;
                    ram_waddr    = '0;
                    ram_wdata    = r_new;
                    n_count      = r_count + CW'(1);
                    n_res_status = STAT_INSERTED;
                    n_state      = ST_RESULT;
                end
            end
            ST_LKP: begin
                n_vld  = issue;
                n_vidx = r_rd_addr;
                if (issue) begin
                    n_rd_left = r_rd_left - CW'(1);
                    n_rd_addr = r_rd_addr + AW'(1);
                end
                if (r_vld && cmp_hit) begin
                    n_vld        = 1'b0;
                    n_rd_left    = '0;
                    n_res_status = STAT_HIT;
                    n_res_gw     = ram_rdata.gateway;
                    n_res_port   = ram_rdata.port;
                    n_state      = ST_RESULT;
                end else if (!issue) begin
                    n_vld        = 1'b0;
                    n_res_status = STAT_MISS;
                    n_state      = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_gw     = r_res_gw;
                    n_out_port   = r_res_port;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_port, r_out_gw};
    assign m_axis_tuser  = r_out_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("route count beyond table depth");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tuser[0] == OP_INSERT && r_count == CW'(TABLE_DEPTH))
        |=> (r_state == ST_RESULT && r_res_status == STAT_FULL && $stable(r_count)))
        else $error("insert on full table not refused");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != STAT_HIT) |-> (m_axis_tdata == '0))
        else $error("nonzero payload on a result that is not a hit");

    a_walk_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_state == ST_INS || r_state == ST_LKP))
        else $error("memory read pending outside a table walk");

endmodule

[sv/lpm_ram.sv]
// route memory, one write port and one registered read port
module lpm_ram
    import lpm_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_route        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_route        o_rdata
);

    t_route r_mem [DEPTH];
    t_route r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/lpm_cmp.sv]
// shared compare unit: mask ordering on insert, prefix match on lookup
module lpm_cmp
    import lpm_pkg::*;
(
    input  t_op               i_op,
    input  t_route            i_entry,
    input  logic [ADDR_W-1:0] i_key,
    output logic              o_hit
);

    always_comb begin
        case (i_op)
            OP_INSERT: o_hit = (i_key >= i_entry.mask);
            OP_LOOKUP: o_hit = (i_entry.dest == (i_entry.mask & i_key));
            default:   o_hit = 1'b0;
        endcase
    end

endmodule

[verif/tb_longest_prefix_match_table.sv]
// testbench for the longest prefix match table: route inserts and lookups checked against a table model
module tb_longest_prefix_match_table;
    import lpm_pkg::*;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned RANDOM_ITEMS = 1030;
    localparam int unsigned CALM_TAIL = 150;
    localparam int unsigned LONG_HOLD = 400;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } t_answer;

    // keeps the routes sorted by mask, largest first, and the answers still owed
    class route_table_model;
        t_route routes[$];
        t_answer pending_answers[$];
        int unsigned capacity;
        int unsigned errors;

        function new(input int unsigned table_depth);
            capacity = table_depth;
            errors = 0;
        endfunction

        function void apply_request(input t_op op, input t_route r, input logic [31:0] addr);
            t_answer ans;
            int unsigned pos;
            ans.status = STAT_MISS;
            ans.gateway = '0;
            ans.port = '0;
            if (op == OP_INSERT) begin
                if (routes.size() >= capacity) begin
                    ans.status = STAT_FULL;
                end else begin
                    // new route goes ahead of any route with an equal or shorter mask
                    pos = routes.size();
                    for (int i = 0; i < routes.size(); i++) begin
                        if (r.mask >= routes[i].mask) begin
                            pos = i;
                            break;
                        end
                    end
                    routes.insert(pos, r);
                    ans.status = STAT_INSERTED;
                end
            end else begin
                for (int i = 0; i < routes.size(); i++) begin
                    if (routes[i].dest == (routes[i].mask & addr)) begin
                        ans.status = STAT_HIT;
                        ans.gateway = routes[i].gateway;
                        ans.port = routes[i].port;
                        break;
                    end
                end
            end
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(input logic [1:0] status, input logic [31:0] gateway,
                                   input logic [15:0] port);
            t_answer want;
            if (pending_answers.size() == 0) begin
                $error("unexpected result beat: status %0d gateway %h port %h",
                       status, gateway, port);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (gateway !== want.gateway) begin
                $error("hit_gateway mismatch: expected %h, got %h", want.gateway, gateway);
                errors++;
            end
            if (port !== want.port) begin
                $error("hit_port mismatch: expected %h, got %h", want.port, port);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_answers.size();
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;  // route_dest, route_mask, route_gateway, route_port, packet_addr
    logic [0:0]   s_axis_tuser;  // op
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;  // hit_gateway, hit_port
    logic [1:0]   m_axis_tuser;  // status

    route_table_model table_model;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned quiet_cycles;
    bit wind_down;

    longest_prefix_match_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        table_model = new(DEPTH);
        items_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        wind_down = 1'b0;
    end

    // input beats feed the model, output beats are checked against it
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            table_model.apply_request(t_op'(s_axis_tuser[0]), t_route'(s_axis_tdata[111:0]),
                                      s_axis_tdata[143:112]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            table_model.check_answer(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32]);
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off so the input backs up
    initial begin : result_sink
        int unsigned hold_count;
        bit long_hold_done;
        long_hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && results_seen >= 300) begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                for (hold_count = 0; hold_count < LONG_HOLD; hold_count++)
                    @(posedge i_clk);
            end else if (!wind_down && (results_seen / 64) % 3 != 2
                         && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic t_route route_of(input logic [31:0] dest, input logic [31:0] mask,
                                        input logic [31:0] gateway, input logic [15:0] port);
        t_route r;
        r.dest = dest;
        r.mask = mask;
        r.gateway = gateway;
        r.port = port;
        return r;
    endfunction

    function automatic logic [31:0] prefix_mask(input int unsigned len);
        // a shift by 32 leaves the default-route mask of zero
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    task automatic issue(input t_op op, input t_route r, input logic [31:0] addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {addr, r};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (!wind_down && (items_sent / 64) % 3 != 1 && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic issue_lookup(input logic [31:0] addr);
        issue(OP_LOOKUP, route_of($urandom, $urandom, $urandom, 16'($urandom)), addr);
    endtask

    task automatic issue_insert(input logic [31:0] dest, input logic [31:0] mask,
                                input logic [31:0] gateway, input logic [15:0] port);
        issue(OP_INSERT, route_of(dest, mask, gateway, port), $urandom);
    endtask

    task automatic random_insert();
        int unsigned kind;
        int unsigned pick;
        logic [31:0] mask;
        logic [31:0] dest;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            mask = $urandom;  // non-contiguous mask
            dest = $urandom & mask;
        end else if (kind == 1) begin
            mask = prefix_mask($urandom_range(0, 32));
            dest = $urandom;  // host bits set, usually unreachable
        end else if (kind <= 3 && table_model.routes.size() != 0) begin
            // same network again: the newer route must win
            pick = $urandom_range(0, table_model.routes.size() - 1);
            mask = table_model.routes[pick].mask;
            dest = table_model.routes[pick].dest;
        end else begin
            if ($urandom_range(0, 1) == 0)
                mask = prefix_mask(8 * $urandom_range(1, 4));
            else
                mask = prefix_mask($urandom_range(0, 32));
            dest = $urandom & mask;
        end
        issue_insert(dest, mask, $urandom, 16'($urandom));
    endtask

    task automatic random_lookup();
        int unsigned pick;
        logic [31:0] addr;
        addr = $urandom;
        if (table_model.routes.size() != 0 && $urandom_range(0, 9) < 7) begin
            pick = $urandom_range(0, table_model.routes.size() - 1);
            addr = table_model.routes[pick].dest | ($urandom & ~table_model.routes[pick].mask);
        end
        issue_lookup(addr);
    endtask

    initial begin : stimulus
        bit do_insert;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= OP_INSERT;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, equal masks, odd masks
        issue_lookup($urandom);
        issue_insert(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        issue_lookup(32'hFFFF_FFFF);
        issue_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
        issue_lookup(32'hFFFF_FFFF);
        issue_lookup(32'h0000_0000);
        issue_insert(32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0001, 16'h0001);
        issue_insert(32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0002, 16'h0002);
        issue_lookup(32'h0A01_0203);
        issue_insert(32'h0012_0034, 32'h00FF_00FF, 32'h5555_AAAA, 16'hA5A5);
        issue_lookup(32'hAB12_CD34);
        issue_insert(32'h0A00_00FF, 32'hFFFF_FF00, 32'hAAAA_5555, 16'h5A5A);
        issue_lookup(32'h0A00_00FF);
        issue(OP_LOOKUP, route_of('1, '1, '1, '1), 32'h0A00_0001);
        issue(OP_LOOKUP, route_of('0, '0, '0, '0), 32'hFEDC_BA98);
        issue(OP_INSERT, route_of(32'hC0A8_0100, 32'hFFFF_FF00, 32'h0102_0304, 16'h8000), '1);
        issue_lookup(32'hC0A8_014D);
        issue_lookup(32'hC0A8_0201);
        issue_insert(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
        issue_lookup(32'h8123_4567);

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - CALM_TAIL)
                wind_down = 1'b1;
            if (table_model.routes.size() < DEPTH)
                do_insert = ($urandom_range(0, 2) == 0);
            else
                do_insert = ($urandom_range(0, 9) == 0);
            if (do_insert)
                random_insert();
            else
                random_lookup();
        end
        s_axis_tvalid <= 1'b0;

        while (table_model.outstanding() != 0) @(posedge i_clk);
        repeat (DEPTH + 16) @(posedge i_clk);
        if (table_model.errors == 0 && table_model.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/lpm_pkg.sv
sv/lpm_ram.sv
sv/lpm_cmp.sv
sv/longest_prefix_match_table.sv
verif/tb_longest_prefix_match_table.sv
